// File: rtl/core/i2cbs_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
package i2cbs_pkg;

  typedef enum logic [2:0] {
    FuncStart = 3'd0,
    FuncStop  = 3'd1,
    FuncWrite = 3'd2,
    FuncRead  = 3'd3,
    FuncTick  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdStop  = 2'd1,
    CmdWrite = 2'd2,
    CmdRead  = 2'd3
  } cmd_e;

  localparam int unsigned BitsPerByte = 8;
  localparam logic [7:0]  MsbMask     = 8'b1000_0000;

  // Step numbers of the fixed pin-action sequences
  localparam logic [4:0] StepFirst     = 5'd1;
  localparam logic [4:0] StepSecond    = 5'd2;
  localparam logic [4:0] StepThird     = 5'd3;
  localparam logic [4:0] WrBitLast     = 5'(2 + 3 * BitsPerByte);
  localparam logic [4:0] WrAckRelease  = 5'd27;
  localparam logic [4:0] WrAckSample   = 5'd28;
  localparam logic [4:0] WrAckClkLow   = 5'd29;
  localparam logic [4:0] WrSdaHigh     = 5'd30;
  localparam logic [4:0] RdBitLast     = 5'(2 + 2 * BitsPerByte);
  localparam logic [4:0] RdDrive       = 5'd19;
  localparam logic [4:0] RdAckSet      = 5'd20;
  localparam logic [4:0] RdAckClkHigh  = 5'd21;
  localparam logic [4:0] RdAckClkLow   = 5'd22;

  typedef struct packed {
    logic [4:0] step;
    logic [3:0] bit_count;
    logic [7:0] shift_byte;
    cmd_e       cmd;
    logic       ack_request;
    logic       scl_out;
    logic       sda_out;
    logic       sda_input_mode;
    logic       ack_flag;
  } state_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] read_byte;
    logic       refused;
  } result_t;

  localparam state_t StateReset = '{
    step:           5'd0,
    bit_count:      4'd0,
    shift_byte:     8'd0,
    cmd:            CmdStart,
    ack_request:    1'b0,
    scl_out:        1'b1,
    sda_out:        1'b1,
    sda_input_mode: 1'b0,
    ack_flag:       1'b0
  };

endpackage

// File: rtl/core/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: input register, step logic, result register.
// A taken transaction is held in the input register, then its result is loaded into the result register.
// Throughput: one transaction per clock while the result stage is not stalled.
// Reset: asynchronous, active low, on state and valid flags; lines high, SDA driven, sequencer idle.
// Result stays until taken; input is stalled only when both stages are full.
module i2c_master_bit_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] func_i,
  input  logic [7:0] data_i,
  input  logic       send_ack_i,
  input  logic       sda_sample_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_level_o,
  output logic       sda_drive_o,
  output logic       sda_release_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic       ack_seen_o,
  output logic [7:0] read_byte_o,
  output logic       refused_o
);

  logic               in_valid_q;
  logic [2:0]         func_q;
  logic [7:0]         data_q;
  logic               send_ack_q;
  logic               sda_sample_q;
  logic               out_valid_q;
  i2cbs_pkg::state_t  state_q, state_d;
  i2cbs_pkg::result_t res_q, res_d;
  logic               out_free;
  logic               advance;
  logic               in_take;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign advance    = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  i2cbs_step u_step (
    .state_i      (state_q),
    .func_i       (func_q),
    .data_i       (data_q),
    .send_ack_i   (send_ack_q),
    .sda_sample_i (sda_sample_q),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= i2cbs_pkg::StateReset;
    end else begin
      if (in_take) in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q       <= func_i;
      data_q       <= data_i;
      send_ack_q   <= send_ack_i;
      sda_sample_q <= sda_sample_i;
    end
    if (advance) res_q <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign scl_level_o   = res_q.scl_level;
  assign sda_drive_o   = res_q.sda_drive;
  assign sda_release_o = res_q.sda_release;
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign ack_seen_o    = res_q.ack_seen;
  assign read_byte_o   = res_q.read_byte;
  assign refused_o     = res_q.refused;

  // a finishing step always leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && !refused_o)
    else $error("done result while still busy or refused");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ack_seen_o || read_byte_o != 8'd0) |-> done_res_o)
    else $error("ack or read data outside a finishing step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_res_o == (state_q.step != 5'd0))
    else $error("busy flag disagrees with sequencer step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |=> in_valid_q && $stable(state_q))
    else $error("state moved while result stage was stalled");

endmodule

// File: rtl/core/i2cbs_step.sv
// Next-state and result logic for one transaction of the bit sequencer.
module i2cbs_step (
  input  i2cbs_pkg::state_t  state_i,
  input  logic [2:0]         func_i,
  input  logic [7:0]         data_i,
  input  logic               send_ack_i,
  input  logic               sda_sample_i,
  output i2cbs_pkg::state_t  state_o,
  output i2cbs_pkg::result_t result_o
);

  always_comb begin
    i2cbs_pkg::state_t st;
    logic       last;
    logic       done;
    logic       refused;
    logic       ack_out;
    logic [7:0] rd_out;
    logic [4:0] s;
    logic [5:0] wr_base;

    st      = state_i;
    last    = 1'b0;
    done    = 1'b0;
    refused = 1'b0;
    ack_out = 1'b0;
    rd_out  = 8'd0;
    s       = state_i.step;
    // write data phase 0 sits at step 3 + 3 * bit_count
    wr_base = {1'b0, state_i.bit_count, 1'b0} + {2'b00, state_i.bit_count} + 6'd3;

    if (func_i <= i2cbs_pkg::FuncRead) begin
      if (state_i.step != 5'd0) begin
        refused = 1'b1;
      end else begin
        st.cmd         = i2cbs_pkg::cmd_e'(func_i[1:0]);
        st.step        = i2cbs_pkg::StepFirst;
        st.bit_count   = 4'd0;
        st.shift_byte  = (func_i == i2cbs_pkg::FuncWrite) ? data_i : 8'd0;
        st.ack_request = send_ack_i;
        if (func_i == i2cbs_pkg::FuncWrite) st.ack_flag = 1'b0;
      end
    end else if (func_i == i2cbs_pkg::FuncTick && state_i.step != 5'd0) begin
      case (state_i.cmd)
        i2cbs_pkg::CmdStart: begin
          if (s == i2cbs_pkg::StepFirst) st.sda_out = 1'b1;
          else if (s == i2cbs_pkg::StepSecond) st.scl_out = 1'b1;
          else if (s == i2cbs_pkg::StepThird) st.sda_out = 1'b0;
          else begin
            st.scl_out = 1'b0;
            last = 1'b1;
          end
        end
        i2cbs_pkg::CmdStop: begin
          if (s == i2cbs_pkg::StepFirst) st.scl_out = 1'b0;
          else if (s == i2cbs_pkg::StepSecond) st.sda_out = 1'b0;
          else if (s == i2cbs_pkg::StepThird) st.scl_out = 1'b1;
          else begin
            st.sda_out = 1'b1;
            last = 1'b1;
          end
        end
        i2cbs_pkg::CmdWrite: begin
          if (s == i2cbs_pkg::StepFirst) st.sda_input_mode = 1'b0;
          else if (s == i2cbs_pkg::StepSecond) st.scl_out = 1'b0;
          else if (s <= i2cbs_pkg::WrBitLast) begin
            if ({1'b0, s} == wr_base) begin
              st.sda_out    = |(state_i.shift_byte & i2cbs_pkg::MsbMask);
              st.shift_byte = {state_i.shift_byte[6:0], 1'b0};
            end else if ({1'b0, s} == wr_base + 6'd1) begin
              st.scl_out = 1'b1;
            end else begin
              st.scl_out   = 1'b0;
              st.bit_count = state_i.bit_count + 4'd1;
            end
          end else if (s == i2cbs_pkg::WrAckRelease) st.sda_input_mode = 1'b1;
          else if (s == i2cbs_pkg::WrAckSample) begin
            st.scl_out  = 1'b1;
            st.ack_flag = ~sda_sample_i;
          end else if (s == i2cbs_pkg::WrAckClkLow) st.scl_out = 1'b0;
          else if (s == i2cbs_pkg::WrSdaHigh) st.sda_out = 1'b1;
          else begin
            st.sda_input_mode = 1'b0;
            last = 1'b1;
          end
        end
        i2cbs_pkg::CmdRead: begin
          if (s == i2cbs_pkg::StepFirst) st.scl_out = 1'b0;
          else if (s == i2cbs_pkg::StepSecond) st.sda_input_mode = 1'b1;
          else if (s <= i2cbs_pkg::RdBitLast) begin
            // odd steps raise SCL and sample, even steps lower it
            if (s[0]) begin
              st.scl_out    = 1'b1;
              st.shift_byte = {state_i.shift_byte[6:0], sda_sample_i};
            end else begin
              st.scl_out   = 1'b0;
              st.bit_count = state_i.bit_count + 4'd1;
            end
          end else if (s == i2cbs_pkg::RdDrive) st.sda_input_mode = 1'b0;
          else if (s == i2cbs_pkg::RdAckSet) begin
            if (state_i.ack_request) st.sda_out = 1'b0;
          end else if (s == i2cbs_pkg::RdAckClkHigh) st.scl_out = 1'b1;
          else if (s == i2cbs_pkg::RdAckClkLow) st.scl_out = 1'b0;
          else begin
            st.sda_out = 1'b1;
            last = 1'b1;
          end
        end
        default: begin
          last = 1'b1;
        end
      endcase

      if (last) begin
        done = 1'b1;
        if (state_i.cmd == i2cbs_pkg::CmdWrite) ack_out = st.ack_flag;
        if (state_i.cmd == i2cbs_pkg::CmdRead) rd_out = st.shift_byte;
        st.step = 5'd0;
      end else begin
        st.step = s + 5'd1;
      end
    end

    state_o              = st;
    result_o.scl_level   = st.scl_out;
    result_o.sda_drive   = st.sda_out;
    result_o.sda_release = st.sda_input_mode;
    result_o.busy_res    = (st.step != 5'd0);
    result_o.done_res    = done;
    result_o.ack_seen    = ack_out;
    result_o.read_byte   = rd_out;
    result_o.refused     = refused;
  end

endmodule
